@@ src/biv_pkg.sv @@
// ---------------------------------------------------------------------------
// biv_pkg: boot image verifier shared definitions
// Constants, widths and result codes used by the verifier and its CRC unit.
// ---------------------------------------------------------------------------
`default_nettype none

package biv_pkg;

	localparam int unsigned SEARCH_WORDS    = 2048;
	localparam int unsigned MAX_IMAGE_BYTES = 1048576;

	localparam int unsigned WC_W   = 19;
	localparam int unsigned SIZE_W = 21;
	localparam int unsigned HPOS_W = 12;

	localparam logic [31:0] SIG_FIRST  = 32'hAA55_FADE;
	localparam logic [31:0] SIG_SECOND = 32'h55AA_C0DE;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

	typedef enum logic [2:0] {
		V_BOOT      = 3'd0,
		V_SWAP      = 3'd1,
		V_ERASED    = 3'd2,
		V_NO_HEADER = 3'd3,
		V_CRC_FAIL  = 3'd4,
		V_BAD_SIZE  = 3'd5
	} verdict_t;

endpackage

`default_nettype wire

@@ src/biv_crc.sv @@
// ---------------------------------------------------------------------------
// biv_crc: reflected CRC-32 word update
// Folds the low one to four bytes of a word, lowest byte first, into a CRC.
// ---------------------------------------------------------------------------
`default_nettype none

module biv_crc (
	input  wire logic [31:0] crc_in,
	input  wire logic [31:0] data,
	input  wire logic [1:0]  last_byte,
	output logic      [31:0] crc_out
);

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ biv_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [31:0] c1, c2, c3, c4;

	assign c1 = crc_byte(crc_in, data[7:0]);
	assign c2 = crc_byte(c1, data[15:8]);
	assign c3 = crc_byte(c2, data[23:16]);
	assign c4 = crc_byte(c3, data[31:24]);

	always_comb begin
		case (last_byte)
			2'd0:    crc_out = c1;
			2'd1:    crc_out = c2;
			2'd2:    crc_out = c3;
			default: crc_out = c4;
		endcase
	end

endmodule

`default_nettype wire

@@ src/boot_image_verifier.sv @@
// ---------------------------------------------------------------------------
// boot_image_verifier: streaming firmware image check before boot
// Captures stack and entry words, finds the signature header, runs CRC-32
// over the image words outside the header and reports at most one verdict per image.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | image_word, first_word
//  out     | out_valid / out_stall | verdict, stack_pointer, entry_address,
//          |                       | computed_crc, header_position
//  cfg     | cfg_wr_en             | cfg_wr_data (bank_a_first)
//
//  One word per cycle while in_stall is low: input register, one step of
//  header/CRC logic, result register. The word that decides a verdict sits
//  in the input register; the verdict is then loaded into the result register.
//  The four-byte CRC update is a single combinational XOR network.
//  in_stall rises only while the result register holds an untaken verdict
//  and the input register is occupied.
//  Reset (arst_n low) returns to idle; words are ignored until first_word.
// ---------------------------------------------------------------------------
`default_nettype none

module boot_image_verifier (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [31:0]               image_word,
	input  wire logic                      first_word,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [2:0]                     verdict,
	output logic [31:0]                    stack_pointer,
	output logic [31:0]                    entry_address,
	output logic [31:0]                    computed_crc,
	output logic [biv_pkg::HPOS_W-1:0]     header_position,
	input  wire logic                      cfg_wr_en,
	input  wire logic                      cfg_wr_data
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEARCH,
		PH_SIZE,
		PH_CRCWORD,
		PH_BODY,
		PH_DONE
	} phase_t;

	localparam int unsigned WC_W   = biv_pkg::WC_W;
	localparam int unsigned SIZE_W = biv_pkg::SIZE_W;
	localparam int unsigned HPOS_W = biv_pkg::HPOS_W;

	// input register
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        first_s1;

	// result register
	logic                 valid_s2;
	biv_pkg::verdict_t    verdict_s2;
	logic [31:0]          stack_s2;
	logic [31:0]          entry_s2;
	logic [31:0]          crc_s2;
	logic [HPOS_W-1:0]    pos_s2;

	// state
	logic              bank_a_first_q;
	phase_t            phase_q;
	logic [31:0]       running_crc_q;
	logic [31:0]       cbp_q;
	logic [31:0]       prev_word_q;
	logic [WC_W-1:0]   wc_q;
	logic [HPOS_W-1:0] hidx_q;
	logic [SIZE_W-1:0] size_q;
	logic [31:0]       exp_crc_q;
	logic [31:0]       stack_q;
	logic [31:0]       entry_q;

	phase_t            nxt_phase;
	logic [31:0]       nxt_running, nxt_cbp, nxt_prev, nxt_exp, nxt_stack, nxt_entry;
	logic [WC_W-1:0]   nxt_wc;
	logic [HPOS_W-1:0] nxt_hidx;
	logic [SIZE_W-1:0] nxt_size;

	logic              emit;
	logic              do_finish;
	biv_pkg::verdict_t emit_verdict;
	logic [31:0]       emit_crc;
	logic [HPOS_W-1:0] emit_pos;
	logic [31:0]       fin_crc;

	logic [31:0]       crc_in;
	logic [1:0]        crc_last;
	logic [31:0]       crc_out;

	logic [SIZE_W-1:0] body_done;
	logic [SIZE_W-1:0] body_left;
	logic [SIZE_W-1:0] hdr_end;
	logic [SIZE_W-1:0] crcword_end;
	logic [WC_W-1:0]   wc_inc;

	logic adv;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	biv_crc u_crc (
		.crc_in    (crc_in),
		.data      (word_s1),
		.last_byte (crc_last),
		.crc_out   (crc_out)
	);

	assign wc_inc      = wc_q + WC_W'(1);
	assign body_done   = {wc_q, 2'b00};
	assign body_left   = size_q - body_done;
	assign hdr_end     = {wc_q + WC_W'(2), 2'b00};
	assign crcword_end = {wc_inc, 2'b00};

	always_comb begin
		nxt_phase    = phase_q;
		nxt_running  = running_crc_q;
		nxt_cbp      = cbp_q;
		nxt_prev     = prev_word_q;
		nxt_wc       = wc_q;
		nxt_hidx     = hidx_q;
		nxt_size     = size_q;
		nxt_exp      = exp_crc_q;
		nxt_stack    = stack_q;
		nxt_entry    = entry_q;
		emit         = 1'b0;
		do_finish    = 1'b0;
		emit_verdict = biv_pkg::V_BOOT;
		emit_crc     = '0;
		emit_pos     = '0;
		crc_in       = running_crc_q;
		crc_last     = 2'd3;
		fin_crc      = '0;

		if (first_s1) begin
			crc_in      = biv_pkg::ALL_ONES;
			nxt_running = biv_pkg::ALL_ONES;
			nxt_cbp     = biv_pkg::ALL_ONES;
			nxt_hidx    = '0;
			nxt_size    = '0;
			nxt_exp     = '0;
			nxt_entry   = '0;
			nxt_stack   = word_s1;
			if (word_s1 == biv_pkg::ALL_ONES) begin
				nxt_prev     = '0;
				nxt_wc       = '0;
				emit         = 1'b1;
				emit_verdict = biv_pkg::V_ERASED;
				nxt_phase    = PH_DONE;
			end else begin
				nxt_running = crc_out;
				nxt_prev    = word_s1;
				nxt_wc      = WC_W'(1);
				nxt_phase   = PH_SEARCH;
			end
		end else begin
			unique case (phase_q)
				PH_SEARCH: begin
					if (wc_q == WC_W'(1))
						nxt_entry = word_s1;
					if (prev_word_q == biv_pkg::SIG_FIRST && word_s1 == biv_pkg::SIG_SECOND) begin
						nxt_running = cbp_q;
						nxt_hidx    = HPOS_W'(wc_q - WC_W'(1));
						nxt_wc      = wc_inc;
						nxt_phase   = PH_SIZE;
					end else if (wc_q > WC_W'(biv_pkg::SEARCH_WORDS)) begin
						emit         = 1'b1;
						emit_verdict = biv_pkg::V_NO_HEADER;
						nxt_phase    = PH_DONE;
					end else begin
						nxt_cbp     = running_crc_q;
						nxt_running = crc_out;
						nxt_prev    = word_s1;
						nxt_wc      = wc_inc;
					end
				end
				PH_SIZE: begin
					if (word_s1 > 32'(biv_pkg::MAX_IMAGE_BYTES) ||
					    word_s1 < {{(32-SIZE_W){1'b0}}, hdr_end}) begin
						emit         = 1'b1;
						emit_verdict = biv_pkg::V_BAD_SIZE;
						emit_pos     = hidx_q;
						nxt_phase    = PH_DONE;
					end else begin
						nxt_size  = word_s1[SIZE_W-1:0];
						nxt_wc    = wc_inc;
						nxt_phase = PH_CRCWORD;
					end
				end
				PH_CRCWORD: begin
					nxt_exp = word_s1;
					nxt_wc  = wc_inc;
					if (size_q <= crcword_end)
						do_finish = 1'b1;
					else
						nxt_phase = PH_BODY;
				end
				PH_BODY: begin
					crc_last    = (body_left >= SIZE_W'(4)) ? 2'd3 : (body_left[1:0] - 2'd1);
					nxt_running = crc_out;
					nxt_wc      = wc_inc;
					if (body_left <= SIZE_W'(4))
						do_finish = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (do_finish) begin
			fin_crc   = nxt_running ^ biv_pkg::ALL_ONES;
			emit      = 1'b1;
			emit_crc  = fin_crc;
			emit_pos  = hidx_q;
			nxt_phase = PH_DONE;
			if (fin_crc == nxt_exp)
				emit_verdict = biv_pkg::V_BOOT;
			else if (bank_a_first_q)
				emit_verdict = biv_pkg::V_SWAP;
			else
				emit_verdict = biv_pkg::V_CRC_FAIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			bank_a_first_q <= 1'b0;
			phase_q        <= PH_IDLE;
			running_crc_q  <= biv_pkg::ALL_ONES;
			cbp_q          <= biv_pkg::ALL_ONES;
			prev_word_q    <= '0;
			wc_q           <= '0;
			hidx_q         <= '0;
			size_q         <= '0;
			exp_crc_q      <= '0;
			stack_q        <= '0;
			entry_q        <= '0;
		end else begin
			if (cfg_wr_en)
				bank_a_first_q <= cfg_wr_data;

			if (!in_stall)
				valid_s1 <= in_valid;

			if (valid_s1 && adv) begin
				phase_q       <= nxt_phase;
				running_crc_q <= nxt_running;
				cbp_q         <= nxt_cbp;
				prev_word_q   <= nxt_prev;
				wc_q          <= nxt_wc;
				hidx_q        <= nxt_hidx;
				size_q        <= nxt_size;
				exp_crc_q     <= nxt_exp;
				stack_q       <= nxt_stack;
				entry_q       <= nxt_entry;
			end

			if (valid_s1 && adv && emit)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			word_s1  <= image_word;
			first_s1 <= first_word;
		end
		if (valid_s1 && adv && emit) begin
			verdict_s2 <= emit_verdict;
			stack_s2   <= nxt_stack;
			entry_s2   <= nxt_entry;
			crc_s2     <= emit_crc;
			pos_s2     <= emit_pos;
		end
	end

	assign out_valid       = valid_s2;
	assign verdict         = verdict_s2;
	assign stack_pointer   = stack_s2;
	assign entry_address   = entry_s2;
	assign computed_crc    = crc_s2;
	assign header_position = pos_s2;

	a_stall_needs_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall && valid_s1))
		else $error("input stalled without a pending result");

	a_erased_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == biv_pkg::V_ERASED) |->
		(entry_address == 32'd0 && computed_crc == 32'd0 && header_position == '0))
		else $error("erased verdict with nonzero fields");

	a_size_phase_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SIZE) |-> (wc_q == WC_W'(hidx_q) + WC_W'(2)))
		else $error("word counter out of step with header index");

	a_emit_leaves_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv && emit) |=> (phase_q == PH_DONE && out_valid))
		else $error("verdict issued without reaching done");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict <= 3'(biv_pkg::V_BAD_SIZE)))
		else $error("verdict code out of range");

endmodule

`default_nettype wire

@@ sim/biv_checker.sv @@
// ---------------------------------------------------------------------------
// biv_checker: result predictor and scoreboard for boot_image_verifier
// Watches the image and result channels and the bank mode write port. Every
// accepted image word steps a local model of the header search, size check
// and CRC-32 pass; each verdict it reaches is queued and compared field by
// field with the next result transaction the block delivers.
// ---------------------------------------------------------------------------

package biv_tb_pkg;

	// Reflected CRC-32, low byte of the word first, nbytes of the word used.
	function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [31:0] w,
			input int unsigned nbytes);
		logic [31:0] c;
		int unsigned b;
		int unsigned k;
		c = crc;
		for (b = 0; b < nbytes && b < 4; b++) begin
			c = c ^ {24'd0, w[8*b +: 8]};
			for (k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ biv_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

module biv_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [31:0]                image_word,
	input  logic                       first_word,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [2:0]                 verdict,
	input  logic [31:0]                stack_pointer,
	input  logic [31:0]                entry_address,
	input  logic [31:0]                computed_crc,
	input  logic [biv_pkg::HPOS_W-1:0] header_position,
	input  logic                       cfg_wr_en,
	input  logic                       cfg_wr_data,
	output int                         error_count,
	output int                         verdicts_due
);

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_SEARCH,
		SCAN_SIZE,
		SCAN_CRCWORD,
		SCAN_BODY,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		biv_pkg::verdict_t              v;
		logic [31:0]                    sp;
		logic [31:0]                    entry;
		logic [31:0]                    crc;
		logic [biv_pkg::HPOS_W-1:0]     pos;
	} image_verdict_t;

	logic                         bank_first;
	logic [31:0]                  crc_run;
	logic [31:0]                  crc_prev;
	logic [31:0]                  prev_w;
	logic [biv_pkg::WC_W-1:0]     wcnt;
	scan_phase_t                  ph;
	logic [biv_pkg::HPOS_W-1:0]   hdr_idx;
	logic [biv_pkg::SIZE_W-1:0]   img_size;
	logic [31:0]                  crc_exp;
	logic [31:0]                  stack_w;
	logic [31:0]                  entry_w;
	image_verdict_t               verdict_q[$];
	image_verdict_t               want;
	int                           errors;

	task automatic post_result(input biv_pkg::verdict_t v, input logic [31:0] crc,
			input logic [biv_pkg::HPOS_W-1:0] pos);
		image_verdict_t r;
		r.v = v;
		r.sp = stack_w;
		r.entry = entry_w;
		r.crc = crc;
		r.pos = pos;
		verdict_q.push_back(r);
		ph = SCAN_DONE;
	endtask

	task automatic close_image();
		logic [31:0] crc;
		crc = crc_run ^ biv_pkg::ALL_ONES;
		if (crc == crc_exp)
			post_result(biv_pkg::V_BOOT, crc, hdr_idx);
		else if (bank_first)
			post_result(biv_pkg::V_SWAP, crc, hdr_idx);
		else
			post_result(biv_pkg::V_CRC_FAIL, crc, hdr_idx);
	endtask

	task automatic step_image(input logic [31:0] w, input logic f);
		longint unsigned hdr_end;
		longint unsigned done_b;
		longint unsigned left_b;
		int unsigned nb;
		if (f) begin
			crc_run = biv_pkg::ALL_ONES;
			crc_prev = biv_pkg::ALL_ONES;
			hdr_idx = '0;
			img_size = '0;
			crc_exp = '0;
			entry_w = '0;
			stack_w = w;
			if (w == biv_pkg::ALL_ONES) begin
				prev_w = '0;
				wcnt = '0;
				post_result(biv_pkg::V_ERASED, '0, '0);
			end else begin
				crc_run = biv_tb_pkg::crc32_feed(biv_pkg::ALL_ONES, w, 4);
				prev_w = w;
				wcnt = biv_pkg::WC_W'(1);
				ph = SCAN_SEARCH;
			end
		end else begin
			case (ph)
				SCAN_SEARCH: begin
					if (wcnt == biv_pkg::WC_W'(1))
						entry_w = w;
					if (prev_w == biv_pkg::SIG_FIRST && w == biv_pkg::SIG_SECOND) begin
						crc_run = crc_prev;
						hdr_idx = biv_pkg::HPOS_W'(wcnt - 1'b1);
						wcnt = wcnt + 1'b1;
						ph = SCAN_SIZE;
					end else if (32'(wcnt) - 1 >= biv_pkg::SEARCH_WORDS) begin
						post_result(biv_pkg::V_NO_HEADER, '0, '0);
					end else begin
						crc_prev = crc_run;
						crc_run = biv_tb_pkg::crc32_feed(crc_run, w, 4);
						prev_w = w;
						wcnt = wcnt + 1'b1;
					end
				end
				SCAN_SIZE: begin
					hdr_end = (64'(wcnt) + 64'd2) * 64'd4;
					if (64'(w) < hdr_end || 64'(w) > 64'(biv_pkg::MAX_IMAGE_BYTES)) begin
						post_result(biv_pkg::V_BAD_SIZE, '0, hdr_idx);
					end else begin
						img_size = w[biv_pkg::SIZE_W-1:0];
						wcnt = wcnt + 1'b1;
						ph = SCAN_CRCWORD;
					end
				end
				SCAN_CRCWORD: begin
					crc_exp = w;
					wcnt = wcnt + 1'b1;
					if (64'(img_size) <= 64'(wcnt) * 64'd4)
						close_image();
					else
						ph = SCAN_BODY;
				end
				SCAN_BODY: begin
					done_b = 64'(wcnt) * 64'd4;
					left_b = (64'(img_size) > done_b) ? 64'(img_size) - done_b : 64'd0;
					nb = (left_b >= 64'd4) ? 4 : 32'(left_b);
					crc_run = biv_tb_pkg::crc32_feed(crc_run, w, nb);
					wcnt = wcnt + 1'b1;
					if (left_b <= 64'd4)
						close_image();
				end
				default: begin
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_first = 1'b0;
			crc_run = biv_pkg::ALL_ONES;
			crc_prev = biv_pkg::ALL_ONES;
			prev_w = '0;
			wcnt = '0;
			ph = SCAN_IDLE;
			hdr_idx = '0;
			img_size = '0;
			crc_exp = '0;
			stack_w = '0;
			entry_w = '0;
			verdict_q.delete();
			errors = 0;
			error_count <= 0;
			verdicts_due <= 0;
		end else begin
			if (cfg_wr_en)
				bank_first = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("biv_checker: unexpected v %0d sp %h entry %h crc %h pos %0d",
							verdict, stack_pointer, entry_address, computed_crc,
							header_position);
				end else begin
					want = verdict_q.pop_front();
					if (want.v !== verdict || want.sp !== stack_pointer ||
							want.entry !== entry_address || want.crc !== computed_crc ||
							want.pos !== header_position) begin
						errors++;
						if (errors <= 10) begin
							$display("biv_checker: expected v %0d sp %h entry %h crc %h pos %0d",
								want.v, want.sp, want.entry, want.crc, want.pos);
							$display("biv_checker: got      v %0d sp %h entry %h crc %h pos %0d",
								verdict, stack_pointer, entry_address, computed_crc,
								header_position);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				step_image(image_word, first_word);
			error_count <= errors;
			verdicts_due <= verdict_q.size();
		end
	end

endmodule

@@ sim/tb_boot_image_verifier.sv @@
// ---------------------------------------------------------------------------
// tb_boot_image_verifier: testbench top for boot_image_verifier
// Streams firmware images word by word: a short directed set, then random
// images (erased, bad size, abandoned, good and corrupted CRC) and one
// image with no header, under three sender/receiver idle mixes and both
// bank modes. Checking is done by biv_checker.
// ---------------------------------------------------------------------------

module tb_boot_image_verifier;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [31:0]                  image_word = '0;
	logic                         first_word = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [2:0]                   verdict;
	logic [31:0]                  stack_pointer;
	logic [31:0]                  entry_address;
	logic [31:0]                  computed_crc;
	logic [biv_pkg::HPOS_W-1:0]   header_position;
	logic                         cfg_wr_en = 1'b0;
	logic                         cfg_wr_data = 1'b0;
	logic                         hold_req = 1'b0;
	int                           error_count;
	int                           verdicts_due;
	int                           tx_idle_pct = 0;
	int                           rx_idle_pct = 0;
	int                           words_sent = 0;
	int                           target;

	boot_image_verifier dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.image_word      (image_word),
		.first_word      (first_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.verdict         (verdict),
		.stack_pointer   (stack_pointer),
		.entry_address   (entry_address),
		.computed_crc    (computed_crc),
		.header_position (header_position),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	biv_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.image_word      (image_word),
		.first_word      (first_word),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.verdict         (verdict),
		.stack_pointer   (stack_pointer),
		.entry_address   (entry_address),
		.computed_crc    (computed_crc),
		.header_position (header_position),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.error_count     (error_count),
		.verdicts_due    (verdicts_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stall, or a long hold-off on request
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	initial begin
		#2000000;
		$display("tb_boot_image_verifier: FAIL");
		$finish;
	end

	// one transaction on the image channel; valid stays high afterwards
	task automatic push_word(input logic [31:0] w, input logic f);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		image_word <= w;
		first_word <= f;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (verdicts_due != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bank_mode(input logic v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// hp < 0: no signature pair; a cut from 0 to below the image length abandons the image after cut words
	task automatic send_image(input int hp, input logic [31:0] sz, input bit crc_ok,
			input int cut);
		logic [31:0] words[$];
		logic [31:0] crc;
		longint unsigned hdr_end;
		longint unsigned nbytes;
		int total;
		int i;
		hdr_end = 64'((hp + 4) * 4);
		if (hp < 0)
			total = biv_pkg::SEARCH_WORDS + 2;
		else if (sz < hdr_end || sz > biv_pkg::MAX_IMAGE_BYTES)
			total = hp + 3;
		else
			total = (sz + 3) / 4;
		if (cut >= 0 && cut < total)
			total = cut;
		for (i = 0; i < total; i++) begin
			if (hp < 0 || i < hp)
				words.push_back(($urandom_range(7) == 0) ? biv_pkg::SIG_FIRST : $urandom);
			else if (i == hp)
				words.push_back(biv_pkg::SIG_FIRST);
			else if (i == hp + 1)
				words.push_back(biv_pkg::SIG_SECOND);
			else if (i == hp + 2)
				words.push_back(sz);
			else
				words.push_back($urandom);
		end
		if (hp >= 0 && total > hp + 3) begin
			crc = biv_pkg::ALL_ONES;
			for (i = 0; i < total; i++) begin
				if (i < hp) begin
					crc = biv_tb_pkg::crc32_feed(crc, words[i], 4);
				end else if (i > hp + 3) begin
					nbytes = sz - 4 * i;
					crc = biv_tb_pkg::crc32_feed(crc, words[i],
						32'((nbytes > 4) ? 64'd4 : nbytes));
				end
			end
			crc = crc ^ biv_pkg::ALL_ONES;
			words[hp + 3] = crc_ok ? crc : crc ^ ($urandom | 32'd1);
		end
		for (i = 0; i < total; i++) begin
			push_word(words[i], i == 0);
			words_sent++;
		end
	endtask

	task automatic random_image();
		int r;
		int hp;
		longint unsigned hdr_end;
		logic [31:0] sz;
		r = $urandom_range(99);
		hp = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6);
		hdr_end = 64'((hp + 4) * 4);
		if (r < 8) begin
			push_word(biv_pkg::ALL_ONES, 1'b1);
			words_sent++;
			repeat ($urandom_range(2)) push_word($urandom, 1'b0);
		end else if (r < 18) begin
			case ($urandom_range(3))
				0: sz = 32'(hdr_end - 1);
				1: sz = $urandom_range(32'(hdr_end - 1));
				2: sz = biv_pkg::MAX_IMAGE_BYTES + 1;
				default: sz = $urandom_range(32'hFFFF_FFFF, biv_pkg::MAX_IMAGE_BYTES + 1);
			endcase
			send_image(hp, sz, 1'b1, -1);
		end else if (r < 24) begin
			sz = ($urandom_range(1) == 0) ? biv_pkg::MAX_IMAGE_BYTES
				: $urandom_range(biv_pkg::MAX_IMAGE_BYTES, 32'(hdr_end));
			send_image(hp, sz, 1'b1, hp + 4 + $urandom_range(8));
		end else begin
			sz = 32'(hdr_end) + (($urandom_range(3) == 0) ? 0 : $urandom_range(64));
			send_image(hp, sz, 1'($urandom_range(1)),
				($urandom_range(9) == 0) ? $urandom_range(hp + 20, 1) : -1);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_bank_mode(1'b0);

		// directed: ignored word, erased, header at zero, size limits, crc fail
		push_word($urandom, 1'b0);
		push_word(biv_pkg::ALL_ONES, 1'b1);
		push_word($urandom, 1'b0);
		send_image(0, 16, 1'b1, -1);
		send_image(0, 15, 1'b1, -1);
		send_image(1, biv_pkg::MAX_IMAGE_BYTES + 1, 1'b1, -1);
		send_image(1, 21, 1'b0, -1);
		wait_drained();
		write_bank_mode(1'b1);
		send_image(2, 27, 1'b0, -1);
		wait_drained();

		tx_idle_pct = 17;
		rx_idle_pct <= 69;
		target = words_sent + 100;
		while (words_sent < target)
			random_image();
		// receiver holds off while the sender keeps offering short images
		in_valid <= 1'b0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (8) begin
			push_word(biv_pkg::ALL_ONES, 1'b1);
			words_sent++;
		end
		send_image(0, 16, 1'b1, -1);
		send_image(0, 20, 1'b0, -1);
		wait_drained();
		target = words_sent + 100;
		while (words_sent < target)
			random_image();
		wait_drained();

		write_bank_mode(1'b0);
		tx_idle_pct = 69;
		rx_idle_pct <= 17;
		target = words_sent + 200;
		while (words_sent < target)
			random_image();
		wait_drained();

		write_bank_mode(1'b1);
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		send_image(-1, 0, 1'b0, -1);
		target = words_sent + 50;
		while (words_sent < target)
			random_image();
		wait_drained();

		if (error_count == 0)
			$display("tb_boot_image_verifier: PASS");
		else
			$display("tb_boot_image_verifier: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/biv_pkg.sv
src/biv_crc.sv
src/boot_image_verifier.sv
sim/biv_checker.sv
sim/tb_boot_image_verifier.sv
